### design/plps_pkg.sv
// shared types, codes and constants of the priority lane packet scheduler
package plps_pkg;

  localparam int unsigned CRITICAL_DEPTH_DEF = 2048;
  localparam int unsigned REALTIME_DEPTH_DEF = 64;
  localparam int unsigned BULK_DEPTH_DEF     = 4096;
  localparam int unsigned HEADER_BYTES       = 12;

  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned LEN_W        = 17;
  localparam int unsigned PAYLOAD_W    = 16;
  localparam int unsigned ENTRY_W      = LEN_W + HANDLE_W;
  localparam int unsigned CRIT_LIMIT_W = 12;
  localparam int unsigned RT_LIMIT_W   = 7;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 12;

  localparam logic [CRIT_LIMIT_W-1:0] CRIT_LIMIT_RST = CRIT_LIMIT_W'(2000);
  localparam logic [RT_LIMIT_W-1:0]   RT_LIMIT_RST   = RT_LIMIT_W'(50);

  // command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RT_LIMIT   = 1'b1;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_SVC = 1'b1;

  localparam logic [1:0] LANE_CRIT = 2'd0;
  localparam logic [1:0] LANE_RT   = 2'd1;
  localparam logic [1:0] LANE_BULK = 2'd2;

  localparam logic [1:0] SEND_OK    = 2'd0;
  localparam logic [1:0] SEND_BLOCK = 2'd1;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_IDLE     = 3'd1,
    ST_BLOCK    = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_PARTIAL  = 3'd4,
    ST_ERROR    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_ENQ_CRIT  = 3'd0,
    OP_ENQ_RT    = 3'd1,
    OP_ENQ_BULK  = 3'd2,
    OP_ENQ_BAD   = 3'd3,
    OP_SVC_OK    = 3'd4,
    OP_SVC_BLOCK = 3'd5,
    OP_SVC_ERR   = 3'd6
  } op_t;

  typedef struct packed {
    logic                 command;
    logic [1:0]           lane;
    logic [HANDLE_W-1:0]  packet_handle;
    logic [PAYLOAD_W-1:0] payload_len;
    logic [1:0]           send_status;
    logic [LEN_W-1:0]     sent_bytes;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [1:0]          lane_served;
    logic [HANDLE_W-1:0] head_handle;
    logic [LEN_W-1:0]    bytes_left;
    logic                dropped_oldest;
    logic                dropped_new;
    logic [HANDLE_W-1:0] dropped_handle;
  } out_item_t;

  // classified command; bytes is the full length for an enqueue, sent bytes otherwise
  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    bytes;
  } q_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic upd;
  } lane_op_t;

  typedef struct packed {
    logic nz;
    logic at_limit;
    logic full;
  } lane_stat_t;

endpackage

### design/priority_lane_packet_scheduler_core.sv
// top level of the three lane strict priority packet scheduler
// A command is taken when start is high and busy is low; busy only rises when the
// two entry command queue is full. The back end handles every command in two
// steps, one to read the head entries of all lanes from their registered-read
// memories and one to update the lane and register the result, and it takes no
// new command before both are done. A taken command passes the queue, the fetch
// and execute states and the result register. Every command gives exactly one
// result, held on out_item for the single cycle that out_strobe is high; the
// receiver cannot stall it. Lane memories are not cleared after reset and need no
// start-up time. Limit registers may be written at any time the block is idle.
module priority_lane_packet_scheduler_core #(
  parameter int unsigned CRITICAL_DEPTH = plps_pkg::CRITICAL_DEPTH_DEF,
  parameter int unsigned REALTIME_DEPTH = plps_pkg::REALTIME_DEPTH_DEF,
  parameter int unsigned BULK_DEPTH     = plps_pkg::BULK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  plps_pkg::in_item_t                 in_item,
  output logic                               out_strobe,
  output plps_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [plps_pkg::CRIT_LIMIT_W-1:0] crit_limit_r;
  logic [plps_pkg::RT_LIMIT_W-1:0]   rt_limit_r;
  logic                              q_valid;
  logic                              q_pop;
  plps_pkg::q_item_t                 q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_limit_r <= plps_pkg::CRIT_LIMIT_RST;
      rt_limit_r   <= plps_pkg::RT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        plps_pkg::CFG_CRIT_LIMIT: crit_limit_r <= cfg_data[plps_pkg::CRIT_LIMIT_W-1:0];
        plps_pkg::CFG_RT_LIMIT:   rt_limit_r   <= cfg_data[plps_pkg::RT_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  plps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  plps_back #(
    .CRITICAL_DEPTH (CRITICAL_DEPTH),
    .REALTIME_DEPTH (REALTIME_DEPTH),
    .BULK_DEPTH     (BULK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .crit_limit (crit_limit_r),
    .rt_limit   (rt_limit_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

### design/plps_ram.sv
// generic single write port ram with registered read
module plps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/plps_lane.sv
// one lane: circular entry store with head and count
module plps_lane #(
  parameter int unsigned DEPTH   = plps_pkg::REALTIME_DEPTH_DEF,
  parameter int unsigned LIMIT_W = plps_pkg::RT_LIMIT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  plps_pkg::lane_op_t            lane_op,
  input  logic [plps_pkg::ENTRY_W-1:0]  wdata,
  input  logic [LIMIT_W-1:0]            limit,
  output logic [plps_pkg::ENTRY_W-1:0]  rdata,
  output plps_pkg::lane_stat_t          stat
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic          we;
  logic [AW-1:0] waddr;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // with an eviction the new entry is still written at head + count, the slot just freed only when full
  assign we    = lane_op.push | lane_op.upd;
  assign waddr = lane_op.push ? tail : head_r;

  assign stat.nz       = (count_r != '0);
  assign stat.full     = (count_r >= CW'(DEPTH));
  assign stat.at_limit = stat.nz && ((CMPW'(count_r) >= CMPW'(limit)) || stat.full);

  always_comb begin
    head_nxt  = lane_op.pop ? head_inc : head_r;
    count_nxt = count_r;
    case ({lane_op.push, lane_op.pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  plps_ram #(
    .WIDTH (plps_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (rdata)
  );

endmodule

### design/plps_front.sv
// front end: takes commands, classifies them and queues them for the back end
module plps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plps_pkg::in_item_t  in_item,
  output logic                q_valid,
  output plps_pkg::q_item_t   q_item,
  input  logic                q_pop
);

  plps_pkg::q_item_t            cls;
  plps_pkg::q_item_t            q_mem_r [plps_pkg::QDEPTH];
  logic [plps_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [plps_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         push;

  always_comb begin
    cls.handle = in_item.packet_handle;
    cls.bytes  = in_item.sent_bytes;
    cls.op     = plps_pkg::OP_ENQ_BAD;
    if (in_item.command == plps_pkg::CMD_ENQ) begin
      cls.bytes = plps_pkg::LEN_W'(in_item.payload_len)
                + plps_pkg::LEN_W'(plps_pkg::HEADER_BYTES);
      unique case (in_item.lane)
        plps_pkg::LANE_CRIT: cls.op = plps_pkg::OP_ENQ_CRIT;
        plps_pkg::LANE_RT:   cls.op = plps_pkg::OP_ENQ_RT;
        plps_pkg::LANE_BULK: cls.op = plps_pkg::OP_ENQ_BULK;
        default:             cls.op = plps_pkg::OP_ENQ_BAD;
      endcase
    end else begin
      unique case (in_item.send_status)
        plps_pkg::SEND_OK:    cls.op = plps_pkg::OP_SVC_OK;
        plps_pkg::SEND_BLOCK: cls.op = plps_pkg::OP_SVC_BLOCK;
        default:              cls.op = plps_pkg::OP_SVC_ERR;
      endcase
    end
  end

  assign busy    = (cnt_r == plps_pkg::QCNT_W'(plps_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + plps_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - plps_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + plps_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + plps_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### design/plps_back.sv
// back end: fetches lane heads, applies one command and registers the result
module plps_back #(
  parameter int unsigned CRITICAL_DEPTH = plps_pkg::CRITICAL_DEPTH_DEF,
  parameter int unsigned REALTIME_DEPTH = plps_pkg::REALTIME_DEPTH_DEF,
  parameter int unsigned BULK_DEPTH     = plps_pkg::BULK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  plps_pkg::q_item_t                    q_item,
  output logic                                 q_pop,
  input  logic [plps_pkg::CRIT_LIMIT_W-1:0]    crit_limit,
  input  logic [plps_pkg::RT_LIMIT_W-1:0]      rt_limit,
  output logic                                 out_strobe,
  output plps_pkg::out_item_t                  out_item
);

  typedef enum logic [1:0] {
    BK_FETCH = 2'b01,
    BK_EXEC  = 2'b10
  } bk_state_t;

  bk_state_t                       state_r, state_nxt;
  plps_pkg::q_item_t               itm_r;
  plps_pkg::out_item_t             out_r, res_c;
  logic                            out_valid_r;
  plps_pkg::lane_op_t              op_crit, op_rt, op_bulk;
  plps_pkg::lane_stat_t            st_crit, st_rt, st_bulk;
  logic [plps_pkg::ENTRY_W-1:0]    rd_crit, rd_rt, rd_bulk;
  logic [plps_pkg::ENTRY_W-1:0]    wdata_c;
  logic [plps_pkg::ENTRY_W-1:0]    sel_e;
  logic [plps_pkg::LEN_W-1:0]      rem;
  logic [plps_pkg::HANDLE_W-1:0]   hdl;
  logic                            exec;

  assign exec  = (state_r == BK_EXEC);
  assign q_pop = (state_r == BK_FETCH) && q_valid;

  always_comb begin
    unique case (state_r)
      BK_FETCH: state_nxt = q_valid ? BK_EXEC : BK_FETCH;
      BK_EXEC:  state_nxt = BK_FETCH;
      default:  state_nxt = BK_FETCH;
    endcase
  end

  // strict priority: the head of the first non-empty lane is served
  always_comb begin
    if (st_crit.nz) begin
      sel_e = rd_crit;
    end else if (st_rt.nz) begin
      sel_e = rd_rt;
    end else begin
      sel_e = rd_bulk;
    end
  end

  assign rem = sel_e[plps_pkg::ENTRY_W-1:plps_pkg::HANDLE_W];
  assign hdl = sel_e[plps_pkg::HANDLE_W-1:0];

  always_comb begin
    op_crit = '0;
    op_rt   = '0;
    op_bulk = '0;
    wdata_c = {itm_r.bytes, itm_r.handle};
    res_c   = '0;
    res_c.status = plps_pkg::ST_ENQUEUED;
    unique case (itm_r.op) inside
      plps_pkg::OP_ENQ_CRIT: begin
        op_crit.push = exec;
        op_crit.pop  = exec && st_crit.at_limit;
        if (st_crit.at_limit) begin
          res_c.dropped_oldest = 1'b1;
          res_c.dropped_handle = rd_crit[plps_pkg::HANDLE_W-1:0];
        end
      end
      plps_pkg::OP_ENQ_RT: begin
        op_rt.push = exec;
        op_rt.pop  = exec && st_rt.at_limit;
        if (st_rt.at_limit) begin
          res_c.dropped_oldest = 1'b1;
          res_c.dropped_handle = rd_rt[plps_pkg::HANDLE_W-1:0];
        end
      end
      plps_pkg::OP_ENQ_BULK: begin
        if (st_bulk.full) begin
          res_c.dropped_new    = 1'b1;
          res_c.dropped_handle = itm_r.handle;
        end else begin
          op_bulk.push = exec;
        end
      end
      plps_pkg::OP_SVC_OK, plps_pkg::OP_SVC_BLOCK, plps_pkg::OP_SVC_ERR: begin
        if (!(st_crit.nz || st_rt.nz || st_bulk.nz)) begin
          res_c.status = plps_pkg::ST_IDLE;
        end else begin
          res_c.lane_served = st_crit.nz ? plps_pkg::LANE_CRIT :
                              st_rt.nz   ? plps_pkg::LANE_RT : plps_pkg::LANE_BULK;
          res_c.head_handle = hdl;
          res_c.bytes_left  = rem;
          if (itm_r.op == plps_pkg::OP_SVC_BLOCK) begin
            res_c.status = plps_pkg::ST_BLOCK;
          end else if (itm_r.op == plps_pkg::OP_SVC_ERR) begin
            res_c.status = plps_pkg::ST_ERROR;
          end else if (itm_r.bytes >= rem) begin
            res_c.status     = plps_pkg::ST_COMPLETE;
            res_c.bytes_left = '0;
            op_crit.pop = exec && st_crit.nz;
            op_rt.pop   = exec && !st_crit.nz && st_rt.nz;
            op_bulk.pop = exec && !st_crit.nz && !st_rt.nz;
          end else begin
            res_c.status     = plps_pkg::ST_PARTIAL;
            res_c.bytes_left = rem - itm_r.bytes;
            wdata_c          = {rem - itm_r.bytes, hdl};
            op_crit.upd = exec && st_crit.nz;
            op_rt.upd   = exec && !st_crit.nz && st_rt.nz;
            op_bulk.upd = exec && !st_crit.nz && !st_rt.nz;
          end
        end
      end
      default: begin
        // invalid lane: the packet is refused and nothing is stored
        res_c.dropped_new    = 1'b1;
        res_c.dropped_handle = itm_r.handle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      itm_r <= q_item;
    end
    if (exec) begin
      out_r <= res_c;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  plps_lane #(
    .DEPTH   (CRITICAL_DEPTH),
    .LIMIT_W (plps_pkg::CRIT_LIMIT_W)
  ) u_lane_crit (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (q_pop),
    .lane_op (op_crit),
    .wdata   (wdata_c),
    .limit   (crit_limit),
    .rdata   (rd_crit),
    .stat    (st_crit)
  );

  plps_lane #(
    .DEPTH   (REALTIME_DEPTH),
    .LIMIT_W (plps_pkg::RT_LIMIT_W)
  ) u_lane_rt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (q_pop),
    .lane_op (op_rt),
    .wdata   (wdata_c),
    .limit   (rt_limit),
    .rdata   (rd_rt),
    .stat    (st_rt)
  );

  // bulk lane has no eviction limit, only its full and non-empty flags are used
  plps_lane #(
    .DEPTH   (BULK_DEPTH),
    .LIMIT_W (1)
  ) u_lane_bulk (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (q_pop),
    .lane_op (op_bulk),
    .wdata   (wdata_c),
    .limit   (1'b1),
    .rdata   (rd_bulk),
    .stat    (st_bulk)
  );

endmodule

### design/plps_checker.sv
// port level checks of the scheduler and their bind to the top level
module plps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input plps_pkg::out_item_t out_item
);

  // the back end fetches and executes each transaction before it takes the next
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

  a_no_strobe_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_strobe)
    else $error("result straight after reset");

  a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_item.dropped_oldest && out_item.dropped_new))
    else $error("both drop flags set");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == plps_pkg::ST_IDLE) |->
      (out_item.head_handle == '0 && out_item.bytes_left == '0 &&
       out_item.lane_served == '0 && out_item.dropped_handle == '0))
    else $error("idle result carries data");

  a_busy_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without a new transaction");

endmodule

bind priority_lane_packet_scheduler_core plps_checker u_plps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
